// ===== design/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// Intel HEX parser package
// Shared types, character constants and the hex digit decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam logic [7:0] CharLf      = 8'h0A;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CaseMask    = 8'hDF;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperF  = 8'h46;
  localparam logic [7:0] LetterBias  = 8'h37;
  localparam logic [7:0] RecExtLinear = 8'h04;

  // Result kinds as they appear on the result_kind port.
  typedef enum logic [2:0] {
    KIND_WORD      = 3'd0,
    KIND_RECORD_OK = 3'd1,
    KIND_EOF       = 3'd2,
    KIND_CHECKSUM  = 3'd3,
    KIND_BAD_DIGIT = 3'd4
  } ihex_kind_e;

  // Parser phase, one-hot.
  typedef enum logic [6:0] {
    PH_LEAD  = 7'b000_0001,
    PH_COUNT = 7'b000_0010,
    PH_ADDR  = 7'b000_0100,
    PH_TYPE  = 7'b000_1000,
    PH_DATA  = 7'b001_0000,
    PH_CHECK = 7'b010_0000,
    PH_EOL   = 7'b100_0000
  } ihex_phase_e;

  // One result word leaving the parser core.
  typedef struct packed {
    logic        valid;
    ihex_kind_e  kind;
    logic [31:0] wr_addr;
    logic [15:0] write_data;
    logic [1:0]  byte_enable;
  } ihex_result_t;

  // Hex digit decode: bit 4 is set when the character is a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] folded;
    logic [7:0] diff;
    folded = c & CaseMask;
    if (c >= CharZero && c <= CharNine) begin
      diff = c - CharZero;
      return {1'b1, diff[3:0]};
    end else if (folded >= CharUpperA && folded <= CharUpperF) begin
      diff = folded - LetterBias;
      return {1'b1, diff[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

// ===== design/ihex_in_stage.sv =====
// ----------------------------------------------------------------------------
// Intel HEX parser input stage
// Registers one incoming character and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module ihex_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  input  logic       advance_i,
  output logic       char_valid_o,
  output logic [7:0] char_o
);

  logic       valid_q;
  logic [7:0] char_q;

  assign in_ready_o   = !valid_q || advance_i;
  assign char_valid_o = valid_q;
  assign char_o       = char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= character_i;
    end
  end

endmodule

// ===== design/ihex_core.sv =====
// ----------------------------------------------------------------------------
// Intel HEX parser core
// Per-character record state machine, checksum and word packing.
// ----------------------------------------------------------------------------
module ihex_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            char_i,
  output ihex_pkg::ihex_result_t res_o
);
  import ihex_pkg::*;

  ihex_phase_e phase_q, phase_d;
  logic        nib_pend_q, nib_pend_d;
  logic [3:0]  high_nib_q, high_nib_d;
  logic [1:0]  fbi_q, fbi_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [16:0] byte_addr_q, byte_addr_d;
  logic [7:0]  rec_kind_q, rec_kind_d;
  logic [15:0] page_q, page_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  held_q, held_d;
  logic        halted_q, halted_d;

  logic [4:0]  dig;
  logic [7:0]  byte_val;
  logic [31:0] word_addr;
  logic [16:0] addr_half;

  assign dig       = hex_decode(char_i);
  assign byte_val  = {high_nib_q, dig[3:0]};
  assign addr_half = byte_addr_q >> 1;
  assign word_addr = {page_q, 16'h0000} | {15'h0000, addr_half};

  always_comb begin
    phase_d      = phase_q;
    nib_pend_d   = nib_pend_q;
    high_nib_d   = high_nib_q;
    fbi_d        = fbi_q;
    bytes_left_d = bytes_left_q;
    byte_addr_d  = byte_addr_q;
    rec_kind_d   = rec_kind_q;
    page_d       = page_q;
    sum_d        = sum_q;
    held_d       = held_q;
    halted_d     = halted_q;
    res_o        = '0;

    if (step_i && !halted_q) begin
      if (phase_q == PH_LEAD) begin
        if (char_i != CharLf) begin
          phase_d    = PH_COUNT;
          nib_pend_d = 1'b0;
          sum_d      = 8'h00;
        end
      end else if (phase_q == PH_EOL) begin
        if (char_i == CharLf) begin
          phase_d = PH_LEAD;
        end
      end else if (!dig[4]) begin
        halted_d   = 1'b1;
        res_o.valid = 1'b1;
        res_o.kind  = KIND_BAD_DIGIT;
      end else if (!nib_pend_q) begin
        high_nib_d = dig[3:0];
        nib_pend_d = 1'b1;
      end else begin
        nib_pend_d = 1'b0;
        sum_d      = sum_q + byte_val;
        unique case (phase_q)
          PH_COUNT: begin
            if (byte_val == 8'h00) begin
              halted_d    = 1'b1;
              res_o.valid = 1'b1;
              res_o.kind  = KIND_EOF;
            end else begin
              bytes_left_d = byte_val;
              fbi_d        = 2'd0;
              byte_addr_d  = '0;
              phase_d      = PH_ADDR;
            end
          end
          PH_ADDR: begin
            byte_addr_d = {1'b0, byte_addr_q[7:0], byte_val};
            if (fbi_q == 2'd0) begin
              fbi_d = 2'd1;
            end else begin
              fbi_d   = 2'd0;
              phase_d = PH_TYPE;
            end
          end
          PH_TYPE: begin
            rec_kind_d = byte_val;
            fbi_d      = 2'd0;
            phase_d    = (bytes_left_q == 8'h00) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            if (rec_kind_q == RecExtLinear) begin
              // Extended linear address: page is big-endian.
              if (fbi_q == 2'd0) begin
                page_d = {byte_val, 8'h00};
              end else if (fbi_q == 2'd1) begin
                page_d = {page_q[15:8], byte_val};
              end
            end else if (!byte_addr_q[0]) begin
              held_d = byte_val;
              if (bytes_left_q == 8'h01) begin
                res_o.valid       = 1'b1;
                res_o.kind        = KIND_WORD;
                res_o.wr_addr     = word_addr;
                res_o.write_data  = {8'h00, byte_val};
                res_o.byte_enable = 2'b01;
              end
            end else begin
              res_o.valid   = 1'b1;
              res_o.kind    = KIND_WORD;
              res_o.wr_addr = word_addr;
              if (fbi_q == 2'd0) begin
                res_o.write_data  = {byte_val, 8'h00};
                res_o.byte_enable = 2'b10;
              end else begin
                res_o.write_data  = {byte_val, held_q};
                res_o.byte_enable = 2'b11;
              end
            end
            if (fbi_q != 2'd3) begin
              fbi_d = fbi_q + 2'd1;
            end
            byte_addr_d  = byte_addr_q + 17'd1;
            bytes_left_d = bytes_left_q - 8'd1;
            if (bytes_left_q == 8'h01) begin
              phase_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            res_o.valid = 1'b1;
            if (sum_d != 8'h00) begin
              halted_d   = 1'b1;
              res_o.kind = KIND_CHECKSUM;
            end else begin
              phase_d    = PH_EOL;
              res_o.kind = KIND_RECORD_OK;
            end
          end
          default: begin
            phase_d = PH_EOL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      nib_pend_q   <= 1'b0;
      high_nib_q   <= 4'h0;
      fbi_q        <= 2'd0;
      bytes_left_q <= 8'h00;
      byte_addr_q  <= '0;
      rec_kind_q   <= 8'h00;
      page_q       <= 16'h0000;
      sum_q        <= 8'h00;
      halted_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      nib_pend_q   <= nib_pend_d;
      high_nib_q   <= high_nib_d;
      fbi_q        <= fbi_d;
      bytes_left_q <= bytes_left_d;
      byte_addr_q  <= byte_addr_d;
      rec_kind_q   <= rec_kind_d;
      page_q       <= page_d;
      sum_q        <= sum_d;
      halted_q     <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_o.valid)
    else $error("result produced while halted");

  a_word_has_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_WORD) |-> (res_o.byte_enable != 2'b00))
    else $error("word write without byte enable");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind != KIND_WORD) |->
      (res_o.wr_addr == 32'h0 && res_o.write_data == 16'h0 &&
       res_o.byte_enable == 2'b00))
    else $error("status result carries write payload");

  a_stop_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind != KIND_WORD && res_o.kind != KIND_RECORD_OK) |=>
      halted_q)
    else $error("terminal result did not halt the parser");

endmodule

// ===== design/ihex_out_stage.sv =====
// ----------------------------------------------------------------------------
// Intel HEX parser output stage
// Result register that holds a word until the receiver takes it.
// ----------------------------------------------------------------------------
module ihex_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   char_valid_i,
  input  ihex_pkg::ihex_result_t res_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             result_kind_o,
  output logic [31:0]            wr_addr_o,
  output logic [15:0]            write_data_o,
  output logic [1:0]             byte_enable_o
);
  import ihex_pkg::*;

  logic         valid_q;
  ihex_result_t res_q;

  // The register can take a new result when empty or being drained.
  assign advance_o      = !valid_q || out_ready_i;
  assign out_valid_o    = valid_q;
  assign result_kind_o  = res_q.kind;
  assign wr_addr_o      = res_q.wr_addr;
  assign write_data_o   = res_q.write_data;
  assign byte_enable_o  = res_q.byte_enable;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= char_valid_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && char_valid_i && res_i.valid) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== design/intel_hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Streams hex text in one character per word and emits memory word writes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_ready_o / character_i) carries one ASCII
// character per word. The output channel (out_valid_o / out_ready_i) carries
// at most one result per character: a 16-bit word write with byte enables, a
// record-ok status, end of file, a checksum error or a bad digit.
// A character is captured in an input register, decoded by the parser core
// while it waits there, and its result is registered in the output register,
// where the receiver can take it. Throughput is one character per cycle
// while the output register can take a result, as the core updates its state
// once per character; characters that produce no result flow through too.
// When the receiver stalls, the output register holds its word and the input
// register holds the next character; ready drops only when both are full.
// Reset returns the parser to waiting for the leading character of a line,
// with the upper page cleared. After end of file, a checksum error or a bad
// digit the parser ignores all further characters until the next reset.
// ----------------------------------------------------------------------------
module intel_hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] wr_addr_o,
  output logic [15:0] write_data_o,
  output logic [1:0]  byte_enable_o
);
  import ihex_pkg::*;

  logic         advance;
  logic         char_valid;
  logic [7:0]   char_q;
  ihex_result_t res;

  // Input register: one character waiting for the core.
  ihex_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .advance_i   (advance),
    .char_valid_o(char_valid),
    .char_o      (char_q)
  );

  // The core updates its state only when the result register can take the
  // outcome, so a stalled receiver freezes the parser cleanly.
  ihex_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(char_valid && advance),
    .char_i(char_q),
    .res_o (res)
  );

  ihex_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_valid_i  (char_valid),
    .res_i         (res),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .wr_addr_o     (wr_addr_o),
    .write_data_o  (write_data_o),
    .byte_enable_o (byte_enable_o)
  );

endmodule

// ===== sim/intel_hex_record_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser testbench
// Feeds hex text one character per word and checks every result against a
// cycle-free model of the parser kept inside this testbench. A short table of
// hand-written lines comes first, then random well-formed records, and at the
// end one terminating line (end of file, checksum error, bad digit or short
// line) followed by characters that the halted parser has to ignore.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_test;
  import ihex_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int RandomChars  = 880;
  localparam int HoldOffStart = 200;
  localparam int HoldOffLen   = 80;
  localparam int SteadyFirst  = 400;
  localparam int SteadyLast   = 700;
  localparam int DrainCycles  = 8;

  // One row of hand-written text. The row holds up to 16 characters, right
  // aligned; leading zero bytes are padding and are not sent. When has_value
  // is set, the single result that the row causes must match the typed value.
  typedef struct packed {
    logic [127:0] text;
    logic         has_value;
    ihex_kind_e   kind;
    logic [31:0]  wr_addr;
    logic [15:0]  write_data;
    logic [1:0]   byte_enable;
  } text_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  character_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  result_kind_o;
  logic [31:0] wr_addr_o;
  logic [15:0] write_data_o;
  logic [1:0]  byte_enable_o;

  intel_hex_record_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .character_i    (character_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .wr_addr_o      (wr_addr_o),
    .write_data_o   (write_data_o),
    .byte_enable_o  (byte_enable_o)
  );

  // The opening lines. They walk through an empty line, an odd first byte,
  // a record of an unusual type, lower-case digits, a page record with the
  // largest page, the address wrap past 0xFFFF, junk after the checksum, a
  // leading character other than a colon, full words, and a page record
  // that is longer than two bytes.
  text_row_t opening_rows [17] = '{
    '{"\n",               1'b0, KIND_WORD,      32'h0,         16'h0,    2'd0},
    '{":010001FFFF",      1'b1, KIND_WORD,      32'h0000_0000, 16'hFF00, 2'd2},
    '{"00\n",             1'b1, KIND_RECORD_OK, 32'h0,         16'h0,    2'd0},
    '{":02000004ffffFC\n", 1'b1, KIND_RECORD_OK, 32'h0,        16'h0,    2'd0},
    '{":02FFFF00A5",      1'b1, KIND_WORD,      32'hFFFF_7FFF, 16'hA500, 2'd2},
    '{"5A",               1'b1, KIND_WORD,      32'hFFFF_8000, 16'h005A, 2'd1},
    '{"01 ;junk\r\n",     1'b1, KIND_RECORD_OK, 32'h0,         16'h0,    2'd0},
    '{"\n",               1'b0, KIND_WORD,      32'h0,         16'h0,    2'd0},
    '{"%020000040000FA\n", 1'b1, KIND_RECORD_OK, 32'h0,        16'h0,    2'd0},
    '{":04000000",        1'b0, KIND_WORD,      32'h0,         16'h0,    2'd0},
    '{"1122",             1'b1, KIND_WORD,      32'h0000_0000, 16'h2211, 2'd3},
    '{"3344",             1'b1, KIND_WORD,      32'h0000_0001, 16'h4433, 2'd3},
    '{"52\n",             1'b1, KIND_RECORD_OK, 32'h0,         16'h0,    2'd0},
    '{":03000004123456",  1'b0, KIND_WORD,      32'h0,         16'h0,    2'd0},
    '{"5D\n",             1'b1, KIND_RECORD_OK, 32'h0,         16'h0,    2'd0},
    '{":01000A0077",      1'b0, KIND_WORD,      32'h0,         16'h0,    2'd0},
    '{"7E\n",             1'b0, KIND_WORD,      32'h0,         16'h0,    2'd0}
  };

  // Ways to stop the parser. Only one can be seen per run, since reset is
  // applied once; the run picks one at random.
  text_row_t closing_rows [4] = '{
    '{":00000001FF\n",     1'b1, KIND_EOF,       32'h0, 16'h0, 2'd0},
    '{":02000004000AF1\n", 1'b1, KIND_CHECKSUM,  32'h0, 16'h0, 2'd0},
    '{":01G0\n",           1'b1, KIND_BAD_DIGIT, 32'h0, 16'h0, 2'd0},
    '{":0100\n",           1'b1, KIND_BAD_DIGIT, 32'h0, 16'h0, 2'd0}
  };

  // Parser state as the testbench tracks it.
  ihex_phase_e  hx_phase     = PH_LEAD;
  logic         hx_nib_wait  = 1'b0;
  logic [3:0]   hx_high_nib  = 4'h0;
  logic [1:0]   hx_field_idx = 2'd0;
  logic [7:0]   hx_left      = 8'h0;
  logic [16:0]  hx_baddr     = 17'h0;
  logic [7:0]   hx_rtype     = 8'h0;
  logic [15:0]  hx_page      = 16'h0;
  logic [7:0]   hx_sum       = 8'h0;
  logic [7:0]   hx_low_byte  = 8'h0;
  logic         hx_stopped   = 1'b0;

  ihex_result_t pending_results [$];
  logic [7:0]   line_q [$];

  // A typed value for the row being sent replaces the tracked result.
  logic         use_typed = 1'b0;
  ihex_result_t typed_result;

  int  errors       = 0;
  int  chars_sent   = 0;
  int  cycle_count  = 0;
  int  words_seen   = 0;
  int  records_seen = 0;
  int  results_seen = 0;
  int  closing_pick = 0;
  // Both sides drop their idling while the word count is in this window.
  wire steady = (chars_sent >= SteadyFirst) && (chars_sent < SteadyLast);

  // Walks the tracked parser through one accepted character. found is set
  // when the character causes a result, and res then holds it.
  task automatic parse_char(input logic [7:0] c, output logic found,
                            output ihex_result_t res);
    logic [7:0] folded;
    logic [4:0] digit;
    logic [7:0] value;
    found = 1'b0;
    res   = '0;
    res.valid = 1'b1;
    res.kind  = KIND_WORD;
    folded = c & CaseMask;
    if (c >= CharZero && c <= CharNine) begin
      digit = {1'b1, 4'(c - CharZero)};
    end else if (folded >= CharUpperA && folded <= CharUpperF) begin
      digit = {1'b1, 4'(folded - LetterBias)};
    end else begin
      digit = 5'h00;
    end

    if (hx_stopped) begin
      return;
    end
    // The leading character of a line is dropped; a bare newline there is
    // an empty line and leaves the parser waiting.
    if (hx_phase == PH_LEAD) begin
      if (c != CharLf) begin
        hx_phase    = PH_COUNT;
        hx_nib_wait = 1'b0;
        hx_sum      = 8'h0;
      end
      return;
    end
    if (hx_phase == PH_EOL) begin
      if (c == CharLf) hx_phase = PH_LEAD;
      return;
    end
    if (!digit[4]) begin
      hx_stopped = 1'b1;
      res.kind   = KIND_BAD_DIGIT;
      found      = 1'b1;
      return;
    end
    if (!hx_nib_wait) begin
      hx_high_nib = digit[3:0];
      hx_nib_wait = 1'b1;
      return;
    end
    hx_nib_wait = 1'b0;
    value  = {hx_high_nib, digit[3:0]};
    hx_sum = hx_sum + value;

    case (hx_phase)
      PH_COUNT: begin
        if (value == 8'h0) begin
          hx_stopped = 1'b1;
          res.kind   = KIND_EOF;
          found      = 1'b1;
        end else begin
          hx_left      = value;
          hx_field_idx = 2'd0;
          hx_baddr     = 17'h0;
          hx_phase     = PH_ADDR;
        end
      end
      PH_ADDR: begin
        hx_baddr = {1'b0, hx_baddr[7:0], value};
        if (hx_field_idx == 2'd0) begin
          hx_field_idx = 2'd1;
        end else begin
          hx_field_idx = 2'd0;
          hx_phase     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        hx_rtype     = value;
        hx_field_idx = 2'd0;
        hx_phase     = (hx_left == 8'h0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        res.wr_addr = {hx_page, hx_baddr[16:1]};
        if (hx_rtype == RecExtLinear) begin
          // Page bytes arrive high byte first; extra bytes only count
          // toward the checksum.
          if (hx_field_idx == 2'd0) hx_page = {value, 8'h00};
          else if (hx_field_idx == 2'd1) hx_page[7:0] = value;
        end else if (!hx_baddr[0]) begin
          hx_low_byte = value;
          if (hx_left == 8'd1) begin
            res.write_data  = {8'h00, value};
            res.byte_enable = 2'b01;
            found           = 1'b1;
          end
        end else if (hx_field_idx == 2'd0) begin
          res.write_data  = {value, 8'h00};
          res.byte_enable = 2'b10;
          found           = 1'b1;
        end else begin
          res.write_data  = {value, hx_low_byte};
          res.byte_enable = 2'b11;
          found           = 1'b1;
        end
        if (hx_field_idx != 2'd3) hx_field_idx = hx_field_idx + 2'd1;
        hx_baddr = hx_baddr + 17'd1;
        hx_left  = hx_left - 8'd1;
        if (hx_left == 8'h0) hx_phase = PH_CHECK;
      end
      PH_CHECK: begin
        found = 1'b1;
        if (hx_sum != 8'h0) begin
          hx_stopped = 1'b1;
          res.kind   = KIND_CHECKSUM;
        end else begin
          hx_phase = PH_EOL;
          res.kind = KIND_RECORD_OK;
        end
      end
      default: begin
        hx_phase = PH_EOL;
      end
    endcase
  endtask

  // Offers one character, after an optional random gap, and waits for the
  // parser to take it. Called and returning at a falling edge, so that valid
  // stays high from one word to the next when there is no gap.
  task automatic send_char(input logic [7:0] c);
    int           gap;
    logic         found;
    ihex_result_t res;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 16) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chars_sent++;
    parse_char(c, found, res);
    if (found) pending_results.push_back(use_typed ? typed_result : res);
    @(negedge clk_i);
  endtask

  task automatic send_row(input text_row_t row);
    logic [7:0] ch;
    use_typed                 = row.has_value;
    typed_result              = '0;
    typed_result.valid        = 1'b1;
    typed_result.kind         = row.kind;
    typed_result.wr_addr      = row.wr_addr;
    typed_result.write_data   = row.write_data;
    typed_result.byte_enable  = row.byte_enable;
    for (int i = 15; i >= 0; i--) begin
      ch = row.text[8 * i +: 8];
      if (ch != 8'h00) send_char(ch);
    end
    use_typed = 1'b0;
  endtask

  // A hex digit in either case for letters.
  function automatic logic [7:0] hex_glyph(input logic [3:0] n);
    if (n < 4'd10) return CharZero + 8'(n);
    return ($urandom_range(1) == 0) ? LetterBias + 8'(n) : 8'h57 + 8'(n);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CharLf) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b, inout logic [7:0] sum);
    line_q.push_back(hex_glyph(b[7:4]));
    line_q.push_back(hex_glyph(b[3:0]));
    sum = sum + b;
  endtask

  // Builds one random line into line_q: mostly well-formed records with a
  // correct checksum, now and then an empty line, an odd leading character,
  // a long record, or junk between the checksum and the newline.
  task automatic build_line();
    logic [7:0]  sum;
    logic [7:0]  count;
    logic [7:0]  rtype;
    logic [15:0] addr;
    int          pick;
    line_q.delete();
    sum = 8'h0;
    if ($urandom_range(11) == 0) begin
      line_q.push_back(CharLf);
      return;
    end
    line_q.push_back(($urandom_range(7) == 0) ? junk_char() : 8'h3A);

    pick = $urandom_range(99);
    if (pick < 15)      rtype = RecExtLinear;
    else if (pick < 25) rtype = 8'($urandom_range(255));
    else                rtype = 8'h00;

    pick = $urandom_range(99);
    if (rtype == RecExtLinear) count = (pick < 70) ? 8'd2 : 8'($urandom_range(5, 1));
    else if (pick < 2)         count = 8'($urandom_range(255, 200));
    else if (pick < 15)        count = 8'($urandom_range(32, 9));
    else                       count = 8'($urandom_range(8, 1));

    addr = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF, 16'hFFF8))
                                    : 16'($urandom_range(16'hFFFF));

    push_byte(count, sum);
    push_byte(addr[15:8], sum);
    push_byte(addr[7:0], sum);
    push_byte(rtype, sum);
    for (int i = 0; i < count; i++) push_byte(8'($urandom_range(255)), sum);
    push_byte(8'h00 - sum, sum);

    pick = $urandom_range(99);
    if (pick >= 85) begin
      repeat ($urandom_range(6, 1)) line_q.push_back(junk_char());
    end else if (pick >= 70) begin
      line_q.push_back(8'h0D);
    end
    line_q.push_back(CharLf);
  endtask

  // Clock and the one reset at the start.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random back-pressure, one long hold-off so that the output
  // register and the input register both fill and ready drops, and no
  // back-pressure while the steady window lasts.
  initial begin : result_sink
    logic held_off;
    held_off    = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && chars_sent >= HoldOffStart) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldOffLen) @(negedge clk_i);
      end
      out_ready_i <= steady || ($urandom_range(99) >= 16);
    end
  end

  // Every accepted result is compared field by field with the oldest
  // expected one.
  always @(posedge clk_i) begin : result_check
    ihex_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (result_kind_o == KIND_WORD) words_seen++;
      if (result_kind_o == KIND_RECORD_OK) records_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0d addr %h data %h be %b",
                 $time, result_kind_o, wr_addr_o, write_data_o, byte_enable_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_kind_o !== want.kind) begin
          $display("%0t: result_kind expected %0d, got %0d", $time, want.kind,
                   result_kind_o);
          errors++;
        end
        if (wr_addr_o !== want.wr_addr) begin
          $display("%0t: wr_addr expected %h, got %h", $time, want.wr_addr,
                   wr_addr_o);
          errors++;
        end
        if (write_data_o !== want.write_data) begin
          $display("%0t: write_data expected %h, got %h", $time, want.write_data,
                   write_data_o);
          errors++;
        end
        if (byte_enable_o !== want.byte_enable) begin
          $display("%0t: byte_enable expected %b, got %b", $time, want.byte_enable,
                   byte_enable_o);
          errors++;
        end
      end
    end
  end

  // Stimulus: opening table, random records, one closing line, then text
  // that the stopped parser must swallow without a result.
  initial begin : stimulus
    int random_start;
    in_valid_i  = 1'b0;
    character_i = 8'h00;
    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (opening_rows[i]) send_row(opening_rows[i]);

    random_start = chars_sent;
    while (chars_sent - random_start < RandomChars) begin
      build_line();
      foreach (line_q[i]) send_char(line_q[i]);
    end

    closing_pick = $urandom_range(3);
    send_row(closing_rows[closing_pick]);
    repeat (16) send_char(8'($urandom_range(255)));
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d characters; checked %0d results (%0d word writes, %0d good records)",
             chars_sent, results_seen, words_seen, records_seen);
    $display("parser stopped by %s and then ignored the remaining text",
             closing_rows[closing_pick].kind.name());
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
